### src/nbg_pkg.sv
// ----------------------------------------------------------------------------
// nbg_pkg: shared types and constants of the 2-D gravity integrator
// Body and acceleration word layouts, op and config codes, arithmetic unit request, state codes.
// ----------------------------------------------------------------------------
package nbg_pkg;

  localparam int MAX_BODIES_DEF = 64;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic [1:0] CFG_TIME_STEP  = 2'd0;
  localparam logic [1:0] CFG_GRAV_CONST = 2'd1;
  localparam logic [1:0] CFG_BODY_COUNT = 2'd2;

  typedef struct packed {
    logic        [31:0] mass;
    logic signed [47:0] vel_y;
    logic signed [47:0] vel_x;
    logic signed [47:0] pos_y;
    logic signed [47:0] pos_x;
  } body_t;

  typedef struct packed {
    logic signed [47:0] y;
    logic signed [47:0] x;
  } acc_t;

  typedef enum logic [1:0] {
    AOP_MUL,
    AOP_DIV,
    AOP_SQRT
  } arith_op_e;

  typedef struct packed {
    arith_op_e    op;
    logic [127:0] a;
    logic [127:0] b;
  } arith_req_t;

  typedef enum logic {
    AR_IDLE,
    AR_RUN
  } arith_state_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RD_I,
    ST_RD_J,
    ST_LAT_J,
    ST_ISSUE,
    ST_WAIT,
    ST_ACC_RD_I,
    ST_ACC_WR_I,
    ST_ACC_WR_J,
    ST_UPD_RD,
    ST_UPD_LAT,
    ST_UPD_WB
  } core_state_e;

  // micro-operations run on the shared arithmetic unit
  typedef enum logic [4:0] {
    U_DXX, U_DYY, U_SQRT,
    U_GMJ, U_FI, U_GMI, U_FJ,
    U_CIX, U_DCIX, U_CIY, U_DCIY,
    U_CJX, U_DCJX, U_CJY, U_DCJY,
    U_AVX, U_AAX, U_VVX,
    U_AVY, U_AAY, U_VVY
  } uop_e;

endpackage

### src/nbg_ram.sv
// ----------------------------------------------------------------------------
// nbg_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module nbg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### src/nbg_arith.sv
// ----------------------------------------------------------------------------
// nbg_arith: bit-serial multiply, divide and square-root unit
// MUL: 64 steps, b below 2^64. DIV: 128 steps, restoring. SQRT: 64 steps.
// ----------------------------------------------------------------------------
module nbg_arith (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  nbg_pkg::arith_req_t req_i,
  output logic               done_o,
  output logic [127:0]       res_o
);
  import nbg_pkg::*;

  arith_state_e state_q, state_d;
  logic [7:0]   cnt_q, cnt_d;
  logic         done_q, done_d;
  arith_op_e    op_q;
  logic [127:0] acc_q, a_q, b_q, r_q;

  logic [128:0] div_sh, div_diff;
  logic [129:0] sq_sh, sq_trial, sq_diff;
  logic         div_ge, sq_ge;

  always_comb begin
    div_sh   = {acc_q, a_q[127]};
    div_diff = div_sh - {1'b0, b_q};
    div_ge   = div_sh >= {1'b0, b_q};
    sq_sh    = {acc_q, a_q[127:126]};
    sq_trial = {r_q, 2'b01};
    sq_diff  = sq_sh - sq_trial;
    sq_ge    = sq_sh >= sq_trial;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      AR_IDLE: begin
        if (start_i) begin
          state_d = AR_RUN;
          cnt_d   = (req_i.op == AOP_DIV) ? 8'd128 : 8'd64;
        end
      end
      AR_RUN: begin
        cnt_d = cnt_q - 8'd1;
        if (cnt_q == 8'd1) begin
          state_d = AR_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = AR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AR_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == AR_IDLE && start_i) begin
      op_q  <= req_i.op;
      acc_q <= '0;
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      r_q   <= '0;
    end else if (state_q == AR_RUN) begin
      case (op_q)
        AOP_MUL: begin
          if (b_q[0]) acc_q <= acc_q + a_q;
          a_q <= {a_q[126:0], 1'b0};
          b_q <= {1'b0, b_q[127:1]};
        end
        AOP_DIV: begin
          acc_q <= div_ge ? div_diff[127:0] : div_sh[127:0];
          r_q   <= {r_q[126:0], div_ge};
          a_q   <= {a_q[126:0], 1'b0};
        end
        default: begin
          acc_q <= sq_ge ? sq_diff[127:0] : sq_sh[127:0];
          r_q   <= {r_q[126:0], sq_ge};
          a_q   <= {a_q[125:0], 2'b00};
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = (op_q == AOP_MUL) ? acc_q : r_q;

endmodule

### src/nbg_core.sv
// ----------------------------------------------------------------------------
// nbg_core: sequencer and datapath of the gravity integrator
// Bodies and accelerations live in RAMs; pairs and updates run through the
// shared arithmetic unit one micro-operation at a time.
// ----------------------------------------------------------------------------
module nbg_core #(
  parameter int MAX_BODIES = nbg_pkg::MAX_BODIES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               op_i,
  input  logic [5:0]         body_index_i,
  input  logic signed [47:0] load_pos_x_i,
  input  logic signed [47:0] load_pos_y_i,
  input  logic signed [47:0] load_vel_x_i,
  input  logic signed [47:0] load_vel_y_i,
  input  logic [31:0]        load_mass_i,
  input  logic [31:0]        time_step_i,
  input  logic [31:0]        grav_const_i,
  input  logic [6:0]         body_count_i,
  output logic               out_valid_o,
  output logic [5:0]         out_index_o,
  output logic signed [47:0] out_pos_x_o,
  output logic signed [47:0] out_pos_y_o,
  output logic signed [47:0] out_vel_x_o,
  output logic signed [47:0] out_vel_y_o,
  output logic               last_o
);
  import nbg_pkg::*;

  localparam int AW  = $clog2(MAX_BODIES);
  localparam int NW  = AW + 1;
  localparam int LIM = (MAX_BODIES < 64) ? MAX_BODIES : 64;

  function automatic logic signed [81:0] sgn82(input logic neg, input logic [81:0] m);
    sgn82 = neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [81:0] v);
    logic signed [81:0] hi, lo;
    hi = $signed({34'b0, 48'h7FFF_FFFF_FFFF});
    lo = $signed({{34{1'b1}}, 48'h8000_0000_0000});
    if (v > hi)      sat48 = 48'sh7FFF_FFFF_FFFF;
    else if (v < lo) sat48 = 48'sh8000_0000_0000;
    else             sat48 = v[47:0];
  endfunction

  core_state_e state_q, state_d;
  uop_e        uop_q, uop_d;
  logic [NW-1:0] n_q, n_d;
  logic [AW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;

  // RAM ports
  logic          body_we, acc_we;
  logic [AW-1:0] body_waddr, body_raddr, acc_waddr, acc_raddr;
  body_t         body_wdata, body_rd;
  acc_t          acc_wdata, acc_rd;

  // arithmetic unit
  logic         ar_start, ar_done;
  arith_req_t   ar_req;
  logic [127:0] ar_res;

  // pair and update datapath
  body_t              bi_q, bk_q;
  acc_t               ak_q;
  logic [31:0]        mj_q;
  logic [48:0]        dxm_q, dym_q;
  logic               dxs_q, dys_q;
  logic [97:0]        q_q;
  logic [49:0]        r_q;
  logic [95:0]        t_q;
  logic [46:0]        fi_q, fj_q, cix_q, ciy_q, cjx_q, cjy_q;
  logic signed [47:0] vnx_q, vny_q, pnx_q;
  logic signed [81:0] pax_q, pay_q;
  logic signed [47:0] pny_w;

  logic signed [48:0] dx_w, dy_w;
  logic [47:0]        axm_w, aym_w, vxm_w, vym_w;
  logic [6:0]         nlim_w;
  logic [NW-1:0]      j_inc, i_two, k_inc;
  logic               out_valid_q;

  nbg_ram #(.WIDTH($bits(body_t)), .DEPTH(MAX_BODIES)) u_body_ram (
    .clk_i   (clk_i),
    .we_i    (body_we),
    .waddr_i (body_waddr),
    .wdata_i (body_wdata),
    .raddr_i (body_raddr),
    .rdata_o (body_rd)
  );

  nbg_ram #(.WIDTH($bits(acc_t)), .DEPTH(MAX_BODIES)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rd)
  );

  nbg_arith u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ar_start),
    .req_i   (ar_req),
    .done_o  (ar_done),
    .res_o   (ar_res)
  );

  always_comb begin
    dx_w   = {body_rd.pos_x[47], body_rd.pos_x} - {bi_q.pos_x[47], bi_q.pos_x};
    dy_w   = {body_rd.pos_y[47], body_rd.pos_y} - {bi_q.pos_y[47], bi_q.pos_y};
    axm_w  = ak_q.x[47] ? 48'(-ak_q.x) : 48'(ak_q.x);
    aym_w  = ak_q.y[47] ? 48'(-ak_q.y) : 48'(ak_q.y);
    vxm_w  = vnx_q[47] ? 48'(-vnx_q) : 48'(vnx_q);
    vym_w  = vny_q[47] ? 48'(-vny_q) : 48'(vny_q);
    nlim_w = (body_count_i > 7'(LIM)) ? 7'(LIM) : body_count_i;
    j_inc  = {1'b0, j_q} + NW'(1);
    i_two  = {1'b0, i_q} + NW'(2);
    k_inc  = {1'b0, k_q} + NW'(1);
    pny_w  = sat48(pay_q + sgn82(vny_q[47], 82'(ar_res[79:16])));
  end

  // operand selection for the current micro-operation
  always_comb begin
    ar_req.op = AOP_MUL;
    ar_req.a  = '0;
    ar_req.b  = '0;
    unique case (uop_q)
      U_DXX:  begin ar_req.a = 128'(dxm_q); ar_req.b = 128'(dxm_q); end
      U_DYY:  begin ar_req.a = 128'(dym_q); ar_req.b = 128'(dym_q); end
      U_SQRT: begin ar_req.op = AOP_SQRT; ar_req.a = 128'(q_q); end
      U_GMJ:  begin ar_req.a = 128'(grav_const_i); ar_req.b = 128'(mj_q); end
      U_GMI:  begin ar_req.a = 128'(grav_const_i); ar_req.b = 128'(bi_q.mass); end
      U_FI, U_FJ: begin
        ar_req.op = AOP_DIV;
        ar_req.a  = 128'({t_q[63:0], 16'b0});
        ar_req.b  = 128'(q_q);
      end
      U_CIX:  begin ar_req.a = 128'(fi_q); ar_req.b = 128'(dxm_q); end
      U_CIY:  begin ar_req.a = 128'(fi_q); ar_req.b = 128'(dym_q); end
      U_CJX:  begin ar_req.a = 128'(fj_q); ar_req.b = 128'(dxm_q); end
      U_CJY:  begin ar_req.a = 128'(fj_q); ar_req.b = 128'(dym_q); end
      U_DCIX, U_DCIY, U_DCJX, U_DCJY: begin
        ar_req.op = AOP_DIV;
        ar_req.a  = 128'(t_q);
        ar_req.b  = 128'(r_q);
      end
      U_AVX:  begin ar_req.a = 128'(axm_w); ar_req.b = 128'(time_step_i); end
      U_AVY:  begin ar_req.a = 128'(aym_w); ar_req.b = 128'(time_step_i); end
      U_AAX, U_AAY: begin ar_req.a = 128'(t_q); ar_req.b = 128'(time_step_i); end
      U_VVX:  begin ar_req.a = 128'(vxm_w); ar_req.b = 128'(time_step_i); end
      U_VVY:  begin ar_req.a = 128'(vym_w); ar_req.b = 128'(time_step_i); end
      default: ar_req.op = AOP_MUL;
    endcase
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    uop_d      = uop_q;
    n_d        = n_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    ar_start   = 1'b0;
    body_we    = 1'b0;
    body_waddr = k_q;
    body_wdata = '0;
    body_raddr = k_q;
    acc_we     = 1'b0;
    acc_waddr  = i_q;
    acc_wdata  = '0;
    acc_raddr  = k_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i && op_i == OP_LOAD) begin
          if (32'(body_index_i) < MAX_BODIES) begin
            body_we          = 1'b1;
            body_waddr       = AW'(body_index_i);
            body_wdata.pos_x = load_pos_x_i;
            body_wdata.pos_y = load_pos_y_i;
            body_wdata.vel_x = load_vel_x_i;
            body_wdata.vel_y = load_vel_y_i;
            body_wdata.mass  = load_mass_i;
          end
        end else if (start_i && nlim_w != 7'd0) begin
          n_d     = NW'(nlim_w);
          k_d     = '0;
          state_d = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = k_q;
        if (k_inc < n_q) begin
          k_d = k_inc[AW-1:0];
        end else if (n_q > NW'(1)) begin
          i_d     = '0;
          j_d     = AW'(1);
          state_d = ST_RD_I;
        end else begin
          k_d     = '0;
          state_d = ST_UPD_RD;
        end
      end
      ST_RD_I: begin
        body_raddr = i_q;
        state_d    = ST_RD_J;
      end
      ST_RD_J: begin
        body_raddr = j_q;
        state_d    = ST_LAT_J;
      end
      ST_LAT_J: begin
        if (dx_w == '0 && dy_w == '0) begin
          // coincident bodies: no contribution, straight to the next pair
          if (j_inc < n_q) begin
            j_d     = j_inc[AW-1:0];
            state_d = ST_RD_I;
          end else if (i_two < n_q) begin
            i_d     = i_q + AW'(1);
            j_d     = i_two[AW-1:0];
            state_d = ST_RD_I;
          end else begin
            k_d     = '0;
            state_d = ST_UPD_RD;
          end
        end else begin
          uop_d   = U_DXX;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        ar_start = 1'b1;
        state_d  = ST_WAIT;
      end
      ST_WAIT: begin
        if (ar_done) begin
          if (uop_q == U_DCJY) begin
            state_d = ST_ACC_RD_I;
          end else if (uop_q == U_VVY) begin
            state_d = ST_UPD_WB;
          end else begin
            uop_d   = uop_e'(uop_q + 5'd1);
            state_d = ST_ISSUE;
          end
        end
      end
      ST_ACC_RD_I: begin
        acc_raddr = i_q;
        state_d   = ST_ACC_WR_I;
      end
      ST_ACC_WR_I: begin
        acc_raddr   = j_q;
        acc_we      = 1'b1;
        acc_waddr   = i_q;
        acc_wdata.x = sat48(82'(acc_rd.x) + sgn82(dxs_q, 82'(cix_q)));
        acc_wdata.y = sat48(82'(acc_rd.y) + sgn82(dys_q, 82'(ciy_q)));
        state_d     = ST_ACC_WR_J;
      end
      ST_ACC_WR_J: begin
        acc_we      = 1'b1;
        acc_waddr   = j_q;
        acc_wdata.x = sat48(82'(acc_rd.x) + sgn82(!dxs_q, 82'(cjx_q)));
        acc_wdata.y = sat48(82'(acc_rd.y) + sgn82(!dys_q, 82'(cjy_q)));
        if (j_inc < n_q) begin
          j_d     = j_inc[AW-1:0];
          state_d = ST_RD_I;
        end else if (i_two < n_q) begin
          i_d     = i_q + AW'(1);
          j_d     = i_two[AW-1:0];
          state_d = ST_RD_I;
        end else begin
          k_d     = '0;
          state_d = ST_UPD_RD;
        end
      end
      ST_UPD_RD: begin
        body_raddr = k_q;
        acc_raddr  = k_q;
        state_d    = ST_UPD_LAT;
      end
      ST_UPD_LAT: begin
        uop_d   = U_AVX;
        state_d = ST_ISSUE;
      end
      ST_UPD_WB: begin
        body_we          = 1'b1;
        body_waddr       = k_q;
        body_wdata.mass  = bk_q.mass;
        body_wdata.vel_x = vnx_q;
        body_wdata.vel_y = vny_q;
        body_wdata.pos_x = pnx_q;
        body_wdata.pos_y = pny_w;
        if (k_inc < n_q) begin
          k_d     = k_inc[AW-1:0];
          state_d = ST_UPD_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      uop_q       <= U_DXX;
      n_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      uop_q       <= uop_d;
      n_q         <= n_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      out_valid_q <= (state_q == ST_UPD_WB);
    end
  end

  // datapath captures
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_RD_J: bi_q <= body_rd;
      ST_LAT_J: begin
        mj_q  <= body_rd.mass;
        dxs_q <= dx_w[48];
        dys_q <= dy_w[48];
        dxm_q <= dx_w[48] ? 49'(-dx_w) : 49'(dx_w);
        dym_q <= dy_w[48] ? 49'(-dy_w) : 49'(dy_w);
      end
      ST_UPD_LAT: begin
        bk_q <= body_rd;
        ak_q <= acc_rd;
      end
      ST_WAIT: begin
        if (ar_done) begin
          case (uop_q)
            U_DXX:  q_q <= ar_res[97:0];
            U_DYY:  q_q <= q_q + ar_res[97:0];
            U_SQRT: r_q <= ar_res[49:0];
            U_FI:   fi_q <= (ar_res[127:47] != '0) ? 47'h7FFF_FFFF_FFFF : ar_res[46:0];
            U_FJ:   fj_q <= (ar_res[127:47] != '0) ? 47'h7FFF_FFFF_FFFF : ar_res[46:0];
            U_DCIX: cix_q <= ar_res[46:0];
            U_DCIY: ciy_q <= ar_res[46:0];
            U_DCJX: cjx_q <= ar_res[46:0];
            U_DCJY: cjy_q <= ar_res[46:0];
            U_AVX: begin
              t_q   <= ar_res[95:0];
              vnx_q <= sat48(82'(bk_q.vel_x) + sgn82(ak_q.x[47], 82'(ar_res[79:16])));
            end
            U_AVY: begin
              t_q   <= ar_res[95:0];
              vny_q <= sat48(82'(bk_q.vel_y) + sgn82(ak_q.y[47], 82'(ar_res[79:16])));
            end
            U_AAX: pax_q <= 82'(bk_q.pos_x) + sgn82(ak_q.x[47], 82'(ar_res[111:33]));
            U_AAY: pay_q <= 82'(bk_q.pos_y) + sgn82(ak_q.y[47], 82'(ar_res[111:33]));
            U_VVX: pnx_q <= sat48(pax_q + sgn82(vnx_q[47], 82'(ar_res[79:16])));
            U_VVY: ;
            default: t_q <= ar_res[95:0];
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_UPD_WB) begin
      out_index_o <= 6'(k_q);
      out_pos_x_o <= pnx_q;
      out_pos_y_o <= pny_w;
      out_vel_x_o <= vnx_q;
      out_vel_y_o <= vny_q;
      last_o      <= (k_inc == n_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign busy_o      = (state_q != ST_IDLE);

endmodule

### src/nbody_gravity_step_2d_top.sv
// ----------------------------------------------------------------------------
// nbody_gravity_step_2d_top: direct-sum 2-D gravity integrator
// Configuration registers, step/load command port and result strobe.
// ----------------------------------------------------------------------------
// Usage: a load transaction (op_i = 0) writes one body in the cycle it is
// accepted and leaves busy low; loads to an index at or above MAX_BODIES are
// dropped. A step transaction (op_i = 1) raises busy, clears the
// accelerations, sums the pairwise pull over all pairs i<j using the positions
// held before the step, integrates every body and presents one result per
// body in index order, the final one flagged by last_o. Each result sits on
// the out ports for exactly one cycle, qualified by out_valid_o; there is no
// back-pressure, so the receiver must take it then. busy falls on the cycle
// the last result appears. A step with zero bodies in use does nothing.
// All arithmetic goes through one bit-serial unit; a pair of coincident bodies
// skips it. The user must write configuration only while busy is low; the block
// itself does not enforce it.
// ----------------------------------------------------------------------------
module nbody_gravity_step_2d_top #(
  parameter int MAX_BODIES = nbg_pkg::MAX_BODIES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               op_i,
  input  logic [5:0]         body_index_i,
  input  logic signed [47:0] load_pos_x_i,
  input  logic signed [47:0] load_pos_y_i,
  input  logic signed [47:0] load_vel_x_i,
  input  logic signed [47:0] load_vel_y_i,
  input  logic [31:0]        load_mass_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               out_valid_o,
  output logic [5:0]         out_index_o,
  output logic signed [47:0] out_pos_x_o,
  output logic signed [47:0] out_pos_y_o,
  output logic signed [47:0] out_vel_x_o,
  output logic signed [47:0] out_vel_y_o,
  output logic               last_o
);
  import nbg_pkg::*;

  logic [31:0] time_step_q;
  logic [31:0] grav_const_q;
  logic [6:0]  body_count_q;
  logic        accept;

  // config writes are always taken; an unknown index is dropped
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q  <= 32'd65536;
      grav_const_q <= 32'd65536;
      body_count_q <= 7'd2;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_TIME_STEP:  time_step_q  <= cfg_data_i;
        CFG_GRAV_CONST: grav_const_q <= cfg_data_i;
        CFG_BODY_COUNT: body_count_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  nbg_core #(.MAX_BODIES(MAX_BODIES)) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (accept),
    .busy_o       (busy),
    .op_i         (op_i),
    .body_index_i (body_index_i),
    .load_pos_x_i (load_pos_x_i),
    .load_pos_y_i (load_pos_y_i),
    .load_vel_x_i (load_vel_x_i),
    .load_vel_y_i (load_vel_y_i),
    .load_mass_i  (load_mass_i),
    .time_step_i  (time_step_q),
    .grav_const_i (grav_const_q),
    .body_count_i (body_count_q),
    .out_valid_o  (out_valid_o),
    .out_index_o  (out_index_o),
    .out_pos_x_o  (out_pos_x_o),
    .out_pos_y_o  (out_pos_y_o),
    .out_vel_x_o  (out_vel_x_o),
    .out_vel_y_o  (out_vel_y_o),
    .last_o       (last_o)
  );

`ifndef SYNTHESIS
  // only the final result of a step may appear after busy has dropped
  a_mid_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> busy)
    else $error("non-final result while idle");

  // nothing follows the final result of a step straight away
  a_last_ends_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |=> !out_valid_o)
    else $error("result right after final result");

  a_step_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && op_i == OP_STEP && body_count_q != 7'd0 |=> busy)
    else $error("step transaction did not start");

  a_end_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> out_valid_o && last_o)
    else $error("step ended without final result");
`endif

endmodule
